// File: rtl/sync_framed_packet_parser_top_macros.svh
// Assertion macros for the framed packet parser.
`ifndef SYNC_FRAMED_PACKET_PARSER_TOP_MACROS_SVH
`define SYNC_FRAMED_PACKET_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFPP_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
    else $error("sfpp assertion failed");

// Next-cycle implication, disabled during reset.
`define SFPP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
    else $error("sfpp assertion failed");

`endif

// File: rtl/sfpp_pkg.sv
// Package with types, codes and reset values of the framed packet parser.
`timescale 1ns / 1ps
package sfpp_pkg;

  localparam int unsigned LengthBitsDefault = 8;

  localparam logic [7:0] StartOneReset = 8'hAF;
  localparam logic [7:0] StartTwoReset = 8'hFA;
  localparam logic [7:0] EndOneReset   = 8'hAF;
  localparam logic [7:0] EndTwoReset   = 8'hA0;
  localparam logic [7:0] MaxLenReset   = 8'd64;

  localparam logic [2:0] REG_START_ONE = 3'd0;
  localparam logic [2:0] REG_START_TWO = 3'd1;
  localparam logic [2:0] REG_END_ONE   = 3'd2;
  localparam logic [2:0] REG_END_TWO   = 3'd3;
  localparam logic [2:0] REG_MAX_LEN   = 3'd4;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_SECOND  = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0] start_one;
    logic [7:0] start_two;
    logic [7:0] end_one;
    logic [7:0] end_two;
    logic [7:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      phase;
    logic [7:0]      lagged_sum;
    logic [1:0][7:0] recent;
    logic [3:0][7:0] captured;
  } parse_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] length;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] payload_first;
    logic [7:0] payload_second;
  } result_t;

endpackage

// File: rtl/sfpp_step.sv
// Next-state and result logic for one received byte.
`timescale 1ns / 1ps
module sfpp_step #(
  parameter int unsigned LENGTH_BITS = sfpp_pkg::LengthBitsDefault
) (
  input  sfpp_pkg::cfg_t          cfg_i,
  input  sfpp_pkg::parse_state_t  state_i,
  input  logic [LENGTH_BITS-1:0]  count_i,
  input  logic [7:0]              rx_byte_i,
  output sfpp_pkg::parse_state_t  state_o,
  output logic [LENGTH_BITS-1:0]  count_o,
  output logic                    res_valid_o,
  output sfpp_pkg::result_t       res_o
);
  import sfpp_pkg::*;

  localparam int unsigned CapVal = (1 << LENGTH_BITS) - 1;
  localparam logic [16:0] Cap = 17'(CapVal);

  logic [16:0] len;
  logic [16:0] max_ext;
  logic [16:0] limit;
  logic        end_hit;

  assign len     = 17'(count_i) + 17'd1;
  assign max_ext = 17'(cfg_i.max_len);
  assign limit   = (max_ext > Cap) ? Cap : max_ext;
  assign end_hit = (17'(count_i) >= 17'd3) && (state_i.recent[0] == cfg_i.end_one)
                   && (rx_byte_i == cfg_i.end_two);

  always_comb begin
    state_o     = state_i;
    count_o     = count_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_i.phase)
      PH_SECOND: begin
        if (rx_byte_i == cfg_i.start_two) begin
          state_o.phase      = PH_COLLECT;
          state_o.lagged_sum = '0;
          state_o.recent[0]  = rx_byte_i;
          state_o.recent[1]  = cfg_i.start_one;
          state_o.captured   = '0;
          count_o            = LENGTH_BITS'(2);
        end else if (rx_byte_i != cfg_i.start_one) begin
          state_o.phase = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        if (count_i == LENGTH_BITS'(2)) begin
          state_o.captured[0] = rx_byte_i;
        end else if (count_i == LENGTH_BITS'(4)) begin
          state_o.captured[1] = rx_byte_i;
        end else if (count_i == LENGTH_BITS'(6)) begin
          state_o.captured[2] = rx_byte_i;
        end else if (count_i == LENGTH_BITS'(7)) begin
          state_o.captured[3] = rx_byte_i;
        end
        res_o.length         = len[7:0];
        res_o.address        = state_o.captured[0];
        res_o.command        = state_o.captured[1];
        res_o.payload_first  = state_o.captured[2];
        res_o.payload_second = state_o.captured[3];
        if (end_hit) begin
          res_valid_o   = 1'b1;
          res_o.status  = (state_i.recent[1] == state_i.lagged_sum) ? ST_OK : ST_CSUM_ERR;
          state_o.phase = PH_HUNT;
          count_o       = '0;
        end else if (len >= limit) begin
          res_valid_o   = 1'b1;
          res_o.status  = ST_OVERFLOW;
          state_o.phase = PH_HUNT;
          count_o       = '0;
        end else begin
          if (17'(count_i) >= 17'd4) begin
            state_o.lagged_sum = state_i.lagged_sum + state_i.recent[1];
          end
          state_o.recent[1] = state_i.recent[0];
          state_o.recent[0] = rx_byte_i;
          count_o           = len[LENGTH_BITS-1:0];
        end
      end
      default: begin
        state_o.phase = (rx_byte_i == cfg_i.start_one) ? PH_SECOND : PH_HUNT;
      end
    endcase
  end

endmodule

// File: rtl/sync_framed_packet_parser_top.sv
// Top level of the framed packet parser with additive checksum.
//
//   channel  signals                              direction
//   in       in_valid_i/in_ready_o, rx_byte_i     byte in
//   out      out_valid_o/out_ready_i, frame_*_o   frame result out
//   cfg      cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i   register write
//
// One byte per cycle unless stalled; the result of a closing byte shows in the cycle
// after its transfer. Throughput is set by the single output register: a byte is taken
// whenever it is empty or drained in the same cycle. Reset clears parse state and loads
// register defaults. A stalled output stalls input; config writes are always taken.
`timescale 1ns / 1ps
`include "sync_framed_packet_parser_top_macros.svh"
module sync_framed_packet_parser_top #(
  parameter int unsigned LENGTH_BITS = sfpp_pkg::LengthBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] frame_status_o,
  output logic [7:0] frame_length_o,
  output logic [7:0] frame_address_o,
  output logic [7:0] frame_command_o,
  output logic [7:0] payload_first_o,
  output logic [7:0] payload_second_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import sfpp_pkg::*;

  cfg_t                   cfg_q;
  parse_state_t           state_q, state_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic                   out_valid_q;
  result_t                res_q, res_d;
  logic                   res_valid;
  logic                   in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  sfpp_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .count_i    (count_q),
    .rx_byte_i  (rx_byte_i),
    .state_o    (state_d),
    .count_o    (count_d),
    .res_valid_o(res_valid),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_one <= StartOneReset;
      cfg_q.start_two <= StartTwoReset;
      cfg_q.end_one   <= EndOneReset;
      cfg_q.end_two   <= EndTwoReset;
      cfg_q.max_len   <= MaxLenReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_ONE: cfg_q.start_one <= cfg_data_i;
        REG_START_TWO: cfg_q.start_two <= cfg_data_i;
        REG_END_ONE:   cfg_q.end_one   <= cfg_data_i;
        REG_END_TWO:   cfg_q.end_two   <= cfg_data_i;
        REG_MAX_LEN:   cfg_q.max_len   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      count_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_xfer && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_status_o   = res_q.status;
  assign frame_length_o   = res_q.length;
  assign frame_address_o  = res_q.address;
  assign frame_command_o  = res_q.command;
  assign payload_first_o  = res_q.payload_first;
  assign payload_second_o = res_q.payload_second;

  `SFPP_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, in_ready_o)
  `SFPP_ASSERT_NOW(a_count_in_frame, clk_i, rst_ni, state_q.phase == PH_COLLECT, (17'(count_q) >= 17'd2) && (count_q != '0))
  `SFPP_ASSERT_NEXT(a_no_result_outside_frame, clk_i, rst_ni, in_xfer && (state_q.phase != PH_COLLECT), !out_valid_q)
  `SFPP_ASSERT_NEXT(a_frame_end_rehunts, clk_i, rst_ni, in_xfer && res_valid, (state_q.phase == PH_HUNT) && (count_q == '0))

endmodule

// File: dv/sync_framed_packet_parser_top_tb.sv
// Testbench for the framed packet parser: directed and random byte streams checked by a predictor.
`timescale 1ns / 1ps
module sync_framed_packet_parser_top_tb;
  import sfpp_pkg::*;

  localparam int unsigned LenCap = (1 << LengthBitsDefault) - 1;
  localparam int unsigned RegIndexCount = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] frame_status_o;
  logic [7:0] frame_length_o;
  logic [7:0] frame_address_o;
  logic [7:0] frame_command_o;
  logic [7:0] payload_first_o;
  logic [7:0] payload_second_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  cfg_t        cfg_model;
  logic [1:0]  phase_model;
  int unsigned count_model;
  logic [7:0]  sum_model;
  logic [7:0]  recent_model [2];
  logic [7:0]  fields_model [4];
  result_t     pending_frames [$];
  int unsigned mismatch_count;
  int unsigned collected_bytes;
  int unsigned long_hold_cycles;
  bit          in_idle_en;
  bit          out_idle_en;

  sync_framed_packet_parser_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_status_o  (frame_status_o),
    .frame_length_o  (frame_length_o),
    .frame_address_o (frame_address_o),
    .frame_command_o (frame_command_o),
    .payload_first_o (payload_first_o),
    .payload_second_o(payload_second_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("sync_framed_packet_parser_top_tb NOT OK");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s mismatch, got 0x%02h, expected 0x%02h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int unsigned len_now;
    int unsigned limit;
    result_t     r;
    if (phase_model == PH_SECOND) begin
      if (b == cfg_model.start_two) begin
        phase_model = PH_COLLECT;
        count_model = 2;
        sum_model = '0;
        recent_model[0] = b;
        recent_model[1] = cfg_model.start_one;
        fields_model = '{default: '0};
      end else if (b != cfg_model.start_one) begin
        phase_model = PH_HUNT;
      end
    end else if (phase_model != PH_COLLECT) begin
      phase_model = (b == cfg_model.start_one) ? PH_SECOND : PH_HUNT;
    end else begin
      collected_bytes++;
      len_now = count_model + 1;
      case (count_model)
        2: fields_model[0] = b;
        4: fields_model[1] = b;
        6: fields_model[2] = b;
        7: fields_model[3] = b;
        default: ;
      endcase
      limit = (cfg_model.max_len > LenCap) ? LenCap : cfg_model.max_len;
      r.length = 8'(len_now);
      r.address = fields_model[0];
      r.command = fields_model[1];
      r.payload_first = fields_model[2];
      r.payload_second = fields_model[3];
      if (count_model >= 3 && recent_model[0] == cfg_model.end_one &&
          b == cfg_model.end_two) begin
        r.status = (recent_model[1] == sum_model) ? ST_OK : ST_CSUM_ERR;
        pending_frames.push_back(r);
        phase_model = PH_HUNT;
        count_model = 0;
      end else if (len_now >= limit) begin
        r.status = ST_OVERFLOW;
        pending_frames.push_back(r);
        phase_model = PH_HUNT;
        count_model = 0;
      end else begin
        if (count_model >= 4) sum_model = sum_model + recent_model[1];
        recent_model[1] = recent_model[0];
        recent_model[0] = b;
        count_model = len_now;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = in_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_seq(input logic [7:0] seq [$]);
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  task automatic send_frame(input int unsigned flen, input bit corrupt);
    logic [7:0]  fb [$];
    logic [7:0]  sum;
    logic [7:0]  v;
    int unsigned i;
    fb.push_back(cfg_model.start_one);
    fb.push_back(cfg_model.start_two);
    sum = '0;
    for (i = 2; i + 3 < flen; i++) begin
      do v = 8'($urandom); while (fb[$] == cfg_model.end_one && v == cfg_model.end_two);
      fb.push_back(v);
      sum = sum + v;
    end
    if (flen >= 5) fb.push_back(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    fb.push_back(cfg_model.end_one);
    fb.push_back(cfg_model.end_two);
    send_seq(fb);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_START_ONE: cfg_model.start_one = val;
      REG_START_TWO: cfg_model.start_two = val;
      REG_END_ONE:   cfg_model.end_one = val;
      REG_END_TWO:   cfg_model.end_two = val;
      REG_MAX_LEN:   cfg_model.max_len = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] e1, input logic [7:0] e2,
                              input logic [7:0] ml);
    write_reg(REG_START_ONE, s1);
    write_reg(REG_START_TWO, s2);
    write_reg(REG_END_ONE, e1);
    write_reg(REG_END_TWO, e2);
    write_reg(REG_MAX_LEN, ml);
  endtask

  task automatic test_registers();
    int unsigned idx;
    for (idx = REG_MAX_LEN + 1; idx < RegIndexCount; idx++) write_reg(3'(idx), 8'($urandom));
  endtask

  task automatic test_minimal_frames();
    logic [7:0] seq [$];
    seq = '{cfg_model.start_one, cfg_model.start_two, cfg_model.end_one, cfg_model.end_two};
    send_seq(seq);
    drain();
    apply_config(StartOneReset, 8'h00, EndOneReset, EndTwoReset, MaxLenReset);
    seq = '{cfg_model.start_one, cfg_model.start_two, cfg_model.end_one, cfg_model.end_two};
    send_seq(seq);
    drain();
  endtask

  task automatic test_repeated_start();
    logic [7:0] seq [$];
    apply_config(StartOneReset, StartTwoReset, EndOneReset, EndTwoReset, MaxLenReset);
    seq = '{8'h00, 8'hFF, cfg_model.start_one, cfg_model.start_one, cfg_model.start_one,
            cfg_model.start_two, 8'h00, cfg_model.end_one, cfg_model.end_two};
    send_seq(seq);
    drain();
  endtask

  task automatic test_limits();
    logic [7:0] seq [$];
    apply_config(StartOneReset, StartTwoReset, EndOneReset, EndTwoReset, 8'd3);
    seq = '{cfg_model.start_one, cfg_model.start_two, 8'h5E};
    send_seq(seq);
    drain();
    write_reg(REG_MAX_LEN, 8'd6);
    send_frame(6, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    int k;
    apply_config(StartOneReset, StartTwoReset, EndOneReset, EndTwoReset, MaxLenReset);
    in_idle_en = 1'b0;
    long_hold_cycles = 300;
    for (k = 0; k < 12; k++) send_frame($urandom_range(4, 9), 1'b0);
    drain();
    in_idle_en = 1'b1;
  endtask

  task automatic send_random_chunk();
    int unsigned pick;
    int unsigned limit_len;
    if ($urandom_range(0, 15) == 0) in_idle_en = !in_idle_en;
    if ($urandom_range(0, 15) == 0) out_idle_en = !out_idle_en;
    pick = $urandom_range(0, 99);
    limit_len = (cfg_model.max_len < 4) ? 4 : cfg_model.max_len;
    if (pick < 60) begin
      send_frame($urandom_range(4, (limit_len < 14) ? limit_len : 14), 1'b0);
    end else if (pick < 70) begin
      send_frame($urandom_range(4, limit_len + 2), 1'b0);
    end else if (pick < 82) begin
      send_frame($urandom_range(5, 14), 1'b1);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 6))
        send_byte(($urandom_range(0, 3) == 0) ? cfg_model.start_one : 8'($urandom));
    end else begin
      send_byte(cfg_model.start_one);
      send_byte(cfg_model.start_two);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase_idx;
    int unsigned target;
    for (phase_idx = 0; phase_idx < 5; phase_idx++) begin
      drain();
      case (phase_idx)
        0: apply_config(StartOneReset, StartTwoReset, EndOneReset, EndTwoReset, MaxLenReset);
        1: apply_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'd255);
        2: apply_config(8'hFF, 8'h00, 8'hFF, 8'h00, 8'd6);
        3: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom_range(6, 255)));
        default: apply_config(8'h55, 8'hAA, 8'h5A, 8'hA5, 8'd16);
      endcase
      target = collected_bytes + 290;
      while (collected_bytes < target) send_random_chunk();
    end
    drain();
  endtask

  initial begin : ready_driver
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        long_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (out_idle_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : frame_checker
    result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected frame, length", frame_length_o, 8'h00);
      end else begin
        want = pending_frames.pop_front();
        if (frame_status_o !== want.status)
          report_mismatch("status", {6'b0, frame_status_o}, {6'b0, want.status});
        if (frame_length_o !== want.length)
          report_mismatch("length", frame_length_o, want.length);
        if (frame_address_o !== want.address)
          report_mismatch("address", frame_address_o, want.address);
        if (frame_command_o !== want.command)
          report_mismatch("command", frame_command_o, want.command);
        if (payload_first_o !== want.payload_first)
          report_mismatch("payload_first", payload_first_o, want.payload_first);
        if (payload_second_o !== want.payload_second)
          report_mismatch("payload_second", payload_second_o, want.payload_second);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_START_ONE;
    cfg_data_i = '0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    long_hold_cycles = 0;
    mismatch_count = 0;
    collected_bytes = 0;
    cfg_model = {StartOneReset, StartTwoReset, EndOneReset, EndTwoReset, MaxLenReset};
    phase_model = PH_HUNT;
    count_model = 0;
    sum_model = '0;
    recent_model = '{default: '0};
    fields_model = '{default: '0};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_registers();
    test_minimal_frames();
    test_repeated_start();
    test_limits();
    test_backpressure();
    test_random_traffic();
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("sync_framed_packet_parser_top_tb OK");
    end else begin
      $display("sync_framed_packet_parser_top_tb NOT OK");
    end
    $finish;
  end

endmodule
